/* sv/stq_pkg.sv */
// package for the sorted timer expiry queue
// types, sizes and opcodes shared by the engine and top level
package stq_pkg;
	localparam int TimerSlots = 64;
	localparam int IdW = 6;
	localparam int CntW = $clog2(TimerSlots + 1);
	localparam int PosW = $clog2(TimerSlots);
	localparam int TW = 32;

	typedef enum logic [1:0] {
		OP_SET     = 2'd0,
		OP_ENABLE  = 2'd1,
		OP_DISABLE = 2'd2,
		OP_TICK    = 2'd3
	} opcode_t;

	typedef struct packed {
		logic            expired_valid;
		logic [IdW-1:0]  expired_id;
		logic [TW-1:0]   next_deadline;
		logic            queue_empty;
		logic            last_result;
	} result_t;
endpackage

/* sv/sorted_timer_expiry_queue_top.sv */
// top level of the sorted timer expiry queue
// depends on stq_pkg, stq_engine and stq_ram
//
// After reset the block zeroes its settings tables with in_ready low. A
// request is then taken only while the engine is idle and no result waits.
// The engine walks the sorted list in its ram: it finds the timer and takes
// it out, finds the place for a new deadline and opens the gap for it, then
// reads the head and hands over the result. A tick first counts its due
// timers, then pops them one by one, putting each cyclic timer back in the
// list. Results go out through a one-entry output register; a stalled output
// holds the engine.
module sorted_timer_expiry_queue_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [5:0]  slot_id,
	input  logic [31:0] first_delay,
	input  logic        is_cyclic,
	input  logic [31:0] period,
	input  logic [31:0] now,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        expired_valid,
	output logic [5:0]  expired_id,
	output logic [31:0] next_deadline,
	output logic        queue_empty,
	output logic        last_result
);
	logic busy, push;
	stq_pkg::result_t res, res_q;

	stq_engine u_engine (
		.clk, .arst_n, .start(in_valid && in_ready), .opcode, .slot_id,
		.first_delay, .is_cyclic, .period, .now, .busy, .res_push(push), .res,
		.res_full(out_valid && !out_ready)
	);

	assign in_ready = !busy && !out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (push) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) res_q <= res;
	end

	assign expired_valid = res_q.expired_valid;
	assign expired_id    = res_q.expired_id;
	assign next_deadline = res_q.next_deadline;
	assign queue_empty   = res_q.queue_empty;
	assign last_result   = res_q.last_result;
endmodule

/* sv/stq_ram.sv */
// generic single-port-write, single-read synchronous ram
// registered read, no reset of contents; no dependencies
module stq_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* sv/stq_engine.sv */
// sequencer of the timer queue: settings, sorted list walk, expiry pops
// uses stq_pkg and instances of stq_ram for the sorted list and timer data
module stq_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [1:0]                opcode,
	input  logic [stq_pkg::IdW-1:0]   slot_id,
	input  logic [stq_pkg::TW-1:0]    first_delay,
	input  logic                      is_cyclic,
	input  logic [stq_pkg::TW-1:0]    period,
	input  logic [stq_pkg::TW-1:0]    now,
	output logic                      busy,
	output logic                      res_push,
	output stq_pkg::result_t          res,
	input  logic                      res_full
);
	localparam int N = stq_pkg::TimerSlots;
	localparam int PW = stq_pkg::PosW;
	localparam int CW = stq_pkg::CntW;
	localparam int TW = stq_pkg::TW;
	localparam int IW = stq_pkg::IdW;

	typedef enum logic [19:0] {
		S_CLEAR  = 20'h00001, // zero the delay and period tables after reset
		S_IDLE   = 20'h00002,
		S_USRCH  = 20'h00004, // unlink: read order[pos]
		S_UCMP   = 20'h00008, // unlink: compare with the id
		S_USHR   = 20'h00010, // unlink: read order[pos+1]
		S_USHW   = 20'h00020, // unlink: order[pos] <= order[pos+1]
		S_AFTER  = 20'h00040, // decide on relink
		S_LSRCH  = 20'h00080, // link: read order[pos]
		S_LORD   = 20'h00100, // link: read deadline of that id
		S_LCMP   = 20'h00200,
		S_LSHR   = 20'h00400, // link: read order[sh-1]
		S_LSHW   = 20'h00800, // link: order[sh] <= order[sh-1]
		S_DSRCH  = 20'h01000, // tick: count due timers
		S_DORD   = 20'h02000,
		S_DCMP   = 20'h04000,
		S_PREAD  = 20'h08000, // tick: read head id
		S_PORD   = 20'h10000,
		S_HREAD  = 20'h20000, // read order[0]
		S_HORD   = 20'h40000, // read head deadline
		S_HEMIT  = 20'h80000  // hand the result over
	} state_t;

	state_t             state_q;
	stq_pkg::opcode_t   op_q;
	logic [IW-1:0]      id_q;
	logic [TW-1:0]      now_q, dl_new_q;
	logic [CW-1:0]      cnt_q, pos_q, sh_q, due_q;
	logic               exp_q;

	// rams
	logic          ord_we, dl_we, del_we, per_we;
	logic [PW-1:0] ord_wa, ord_ra, dl_ra, data_wa;
	logic [IW-1:0] ord_wd, ord_rd;
	logic [TW-1:0] dl_rd, del_wd, del_rd;
	logic [TW:0]   per_wd, per_rd; // cyclic flag on top of the period
	logic [PW-1:0] id_a;

	logic [CW-1:0] pos_p1, sh_m1;
	logic [TW-1:0] per_fix;
	logic          slot_ok;

	assign id_a    = id_q[PW-1:0];
	assign pos_p1  = pos_q + CW'(1);
	assign sh_m1   = sh_q - CW'(1);
	assign per_fix = (period == '0) ? TW'(1) : period;
	assign slot_ok = {1'b0, slot_id} < (IW+1)'(N);

	stq_ram #(.Width(IW), .Depth(N)) u_order (
		.clk, .we(ord_we), .waddr(ord_wa), .wdata(ord_wd), .raddr(ord_ra), .rdata(ord_rd)
	);
	stq_ram #(.Width(TW), .Depth(N)) u_deadline (
		.clk, .we(dl_we), .waddr(id_a), .wdata(dl_new_q), .raddr(dl_ra), .rdata(dl_rd)
	);
	stq_ram #(.Width(TW), .Depth(N)) u_delay (
		.clk, .we(del_we), .waddr(data_wa), .wdata(del_wd), .raddr(id_a),
		.rdata(del_rd)
	);
	stq_ram #(.Width(TW+1), .Depth(N)) u_period (
		.clk, .we(per_we), .waddr(data_wa), .wdata(per_wd), .raddr(id_a),
		.rdata(per_rd)
	);

	always_comb begin
		ord_we = 1'b0; ord_wa = pos_q[PW-1:0]; ord_wd = ord_rd;
		ord_ra = pos_q[PW-1:0];
		dl_we = 1'b0; dl_ra = ord_rd[PW-1:0];
		del_we = 1'b0; per_we = 1'b0;
		data_wa = slot_id[PW-1:0]; del_wd = first_delay; per_wd = {is_cyclic, per_fix};
		res_push = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				del_we = 1'b1; per_we = 1'b1;
				data_wa = pos_q[PW-1:0]; del_wd = '0; per_wd = '0;
			end
			S_IDLE: begin
				if (start && opcode == stq_pkg::OP_SET && slot_ok) begin
					del_we = 1'b1; per_we = 1'b1;
				end
			end
			S_USHR: ord_ra = pos_p1[PW-1:0];
			S_USHW: ord_we = 1'b1;
			S_LSHR: begin
				ord_ra = sh_m1[PW-1:0];
				if (sh_q == pos_q) begin
					ord_we = 1'b1; ord_wd = id_q; dl_we = 1'b1;
				end
			end
			S_LSHW: begin
				ord_we = 1'b1; ord_wa = sh_q[PW-1:0];
			end
			S_PREAD, S_PORD, S_HREAD, S_HORD: ord_ra = '0;
			S_HEMIT: begin
				ord_ra = '0;
				res_push = !res_full;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			op_q <= stq_pkg::OP_SET; id_q <= '0; now_q <= '0; dl_new_q <= '0;
			cnt_q <= '0; pos_q <= '0; sh_q <= '0; due_q <= '0; exp_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (pos_q == CW'(N - 1)) begin
						pos_q <= '0;
						state_q <= S_IDLE;
					end else begin
						pos_q <= pos_p1;
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q <= stq_pkg::opcode_t'(opcode);
						id_q <= slot_id; now_q <= now;
						pos_q <= '0; exp_q <= 1'b0;
						if (opcode == stq_pkg::OP_TICK) state_q <= S_DSRCH;
						else if (slot_ok) state_q <= S_USRCH;
						else state_q <= S_HREAD;
					end
				end
				S_USRCH: state_q <= (pos_q == cnt_q) ? S_AFTER : S_UCMP;
				S_UCMP: begin
					if (ord_rd == id_q) begin
						state_q <= S_USHR;
					end else begin
						pos_q <= pos_p1;
						state_q <= S_USRCH;
					end
				end
				S_USHR: begin
					if (pos_p1 >= cnt_q) begin
						cnt_q <= cnt_q - CW'(1);
						state_q <= S_AFTER;
					end else begin
						state_q <= S_USHW;
					end
				end
				S_USHW: begin
					pos_q <= pos_p1;
					state_q <= S_USHR;
				end
				S_AFTER: begin
					pos_q <= '0;
					if (op_q == stq_pkg::OP_TICK ? per_rd[TW] : op_q == stq_pkg::OP_ENABLE) begin
						dl_new_q <= now_q + ((op_q == stq_pkg::OP_TICK) ? per_rd[TW-1:0] : del_rd);
						state_q <= S_LSRCH;
					end else begin
						state_q <= S_HREAD;
					end
				end
				S_LSRCH: begin
					if (pos_q == cnt_q) begin
						sh_q <= cnt_q;
						state_q <= S_LSHR;
					end else begin
						state_q <= S_LORD;
					end
				end
				S_LORD: state_q <= S_LCMP;
				S_LCMP: begin
					if (dl_new_q > dl_rd) begin
						pos_q <= pos_p1;
						state_q <= S_LSRCH;
					end else begin
						sh_q <= cnt_q;
						state_q <= S_LSHR;
					end
				end
				S_LSHR: begin
					if (sh_q == pos_q) begin
						cnt_q <= cnt_q + CW'(1);
						state_q <= S_HREAD;
					end else begin
						state_q <= S_LSHW;
					end
				end
				S_LSHW: begin
					sh_q <= sh_m1;
					state_q <= S_LSHR;
				end
				S_DSRCH: begin
					if (pos_q == cnt_q) begin
						due_q <= pos_q;
						state_q <= (pos_q == '0) ? S_HREAD : S_PREAD;
					end else begin
						state_q <= S_DORD;
					end
				end
				S_DORD: state_q <= S_DCMP;
				S_DCMP: begin
					if (dl_rd <= now_q) begin
						pos_q <= pos_p1;
						state_q <= S_DSRCH;
					end else begin
						due_q <= pos_q;
						state_q <= (pos_q == '0) ? S_HREAD : S_PREAD;
					end
				end
				S_PREAD: state_q <= S_PORD;
				S_PORD: begin
					// the head leaves the list, position 0
					id_q <= ord_rd;
					pos_q <= '0;
					exp_q <= 1'b1;
					state_q <= S_USHR;
				end
				S_HREAD: state_q <= S_HORD;
				S_HORD: state_q <= S_HEMIT;
				S_HEMIT: begin
					if (!res_full) begin
						if (exp_q && due_q != CW'(1)) begin
							due_q <= due_q - CW'(1);
							state_q <= S_PREAD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign res.expired_valid = exp_q;
	assign res.expired_id = exp_q ? id_q : '0;
	assign res.next_deadline = (cnt_q == '0) ? '0 : dl_rd;
	assign res.queue_empty = (cnt_q == '0);
	assign res.last_result = !exp_q || (due_q == CW'(1));

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(N))
		else $error("armed count overflow");
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (state_q == S_IDLE)) else $error("request while busy");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy) else $error("start not taken");
endmodule
